@@ rtl/avrisp_pkg.sv @@
`default_nettype none

package avrisp_pkg;

  localparam logic [3:0] CMD_TICK       = 4'd0;
  localparam logic [3:0] CMD_POWER_UP   = 4'd1;
  localparam logic [3:0] CMD_POWER_DOWN = 4'd2;
  localparam logic [3:0] CMD_SPI_MULTI  = 4'd3;
  localparam logic [3:0] CMD_SPI_SINGLE = 4'd4;
  localparam logic [3:0] CMD_SET_POLL   = 4'd5;
  localparam logic [3:0] CMD_FLASH_RD   = 4'd6;
  localparam logic [3:0] CMD_EEP_RD     = 4'd7;
  localparam logic [3:0] CMD_FLASH_WR   = 4'd8;
  localparam logic [3:0] CMD_EEP_WR     = 4'd9;
  localparam logic [3:0] CMD_READ_BYTE  = 4'd10;
  localparam logic [3:0] CMD_WRITE_BYTE = 4'd11;

  localparam logic [7:0] BASE_FLASH_RD = 8'h20;
  localparam logic [7:0] BASE_EEP_RD   = 8'hA0;
  localparam logic [7:0] BASE_FLASH_WR = 8'h40;
  localparam logic [7:0] BASE_EEP_WR   = 8'hC0;
  localparam logic [7:0] FLASH_HIGH_BIT = 8'h08;
  localparam logic [31:0] POLL_FLIP    = 32'h6000_0000;

  localparam logic [5:0] RW_BITS = 6'd32;

endpackage

`default_nettype wire

@@ rtl/avr_isp_programming_engine.sv @@
// A result beat is presented in the cycle after its input beat is taken.
// Throughput: one input beat per cycle while results are drained; the transfer
// state register is updated once per beat, in the cycle the beat is taken.
// Input is taken whenever the result register is empty or being drained.
// Reset: unpowered, pins released and low, no transfer running, no result held.
`default_nettype none

module avr_isp_programming_engine #(
  parameter int COMMAND_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_cmd,
  input  wire logic        in_miso,
  input  wire logic [15:0] in_value_word,
  input  wire logic [15:0] in_index_word,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_sck_pin,
  output logic             out_mosi_pin,
  output logic             out_reset_pin,
  output logic             out_led_pin,
  output logic             out_drive_enable,
  output logic             out_busy_res,
  output logic             out_accepted,
  output logic             out_done_res,
  output logic [31:0]      out_response
);
  import avrisp_pkg::*;

  localparam int         MULTI_SHIFT = 8 * (4 - COMMAND_BYTES);
  localparam logic [5:0] MULTI_BITS  = 6'(8 * COMMAND_BYTES);

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MULTI,
    OP_SINGLE,
    OP_READ,
    OP_WRITE,
    OP_POLL
  } op_t;

  logic        powered_r, powered_nxt;
  logic        reset_level_r, reset_level_nxt;
  logic [7:0]  half_period_r, half_period_nxt;
  logic [7:0]  poll_first_r, poll_first_nxt;
  logic [7:0]  poll_second_r, poll_second_nxt;
  logic [15:0] next_address_r, next_address_nxt;
  logic [7:0]  base_command_r, base_command_nxt;
  logic [15:0] write_timeout_r, write_timeout_nxt;
  logic [31:0] command_bytes_r, command_bytes_nxt;
  logic [31:0] receive_shift_r, receive_shift_nxt;
  logic [5:0]  bits_left_r, bits_left_nxt;
  logic        clock_phase_r, clock_phase_nxt;
  logic [8:0]  tick_count_r, tick_count_nxt;
  op_t         op_r, op_nxt;
  logic [16:0] poll_elapsed_r, poll_elapsed_nxt;
  logic [7:0]  write_value_r, write_value_nxt;

  logic        out_valid_r;
  logic        sck_r, mosi_r, reset_pin_r, led_r, drive_r, busy_r, acc_r, done_r;
  logic [31:0] resp_r;

  logic        acc, done;
  logic [31:0] resp;
  logic        mosi;
  logic [5:0]  bl_m1;

  logic        take;
  logic [8:0]  period_w;
  logic [8:0]  tick_inc;
  logic [31:0] rx;
  logic [31:0] rx_order;
  logic [31:0] flipped;
  logic [16:0] poll_sum;
  logic        poll_match;
  logic [15:0] addr_sh;
  logic [7:0]  first_byte;
  logic [23:0] rw_hi;
  logic [31:0] multi_raw;

  assign take     = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  assign period_w   = (half_period_r == 8'd0) ? 9'd256 : {1'b0, half_period_r};
  assign tick_inc   = tick_count_r + 9'd1;
  assign rx         = {receive_shift_r[30:0], in_miso};
  assign flipped    = command_bytes_r ^ POLL_FLIP;
  assign poll_sum   = poll_elapsed_r + {3'b000, period_w, 5'b00000};
  assign poll_match = (rx[7:0] == write_value_r) && (rx[7:0] != poll_first_r)
                      && (rx[7:0] != poll_second_r);
  assign addr_sh    = base_command_r[7] ? {next_address_r[14:0], 1'b0} : next_address_r;
  assign first_byte = base_command_r | (addr_sh[0] ? FLASH_HIGH_BIT : 8'h00);
  assign rw_hi      = {first_byte, 1'b0, addr_sh[15:9], addr_sh[8:1]};
  assign multi_raw  = {in_value_word[7:0], in_value_word[15:8],
                       in_index_word[7:0], in_index_word[15:8]} >> MULTI_SHIFT;

  always_comb begin
    rx_order = '0;
    for (int i = 0; i < COMMAND_BYTES; i++) begin
      rx_order[8*i +: 8] = rx[8*(COMMAND_BYTES-1-i) +: 8];
    end
  end

  always_comb begin
    powered_nxt       = powered_r;
    reset_level_nxt   = reset_level_r;
    half_period_nxt   = half_period_r;
    poll_first_nxt    = poll_first_r;
    poll_second_nxt   = poll_second_r;
    next_address_nxt  = next_address_r;
    base_command_nxt  = base_command_r;
    write_timeout_nxt = write_timeout_r;
    command_bytes_nxt = command_bytes_r;
    receive_shift_nxt = receive_shift_r;
    bits_left_nxt     = bits_left_r;
    clock_phase_nxt   = clock_phase_r;
    tick_count_nxt    = tick_count_r;
    op_nxt            = op_r;
    poll_elapsed_nxt  = poll_elapsed_r;
    write_value_nxt   = write_value_r;
    acc               = 1'b0;
    done              = 1'b0;
    resp              = '0;

    if (in_cmd == CMD_TICK) begin
      if (op_r == OP_IDLE || bits_left_r == 6'd0) begin
        op_nxt = OP_IDLE;
      end else if (tick_inc < period_w) begin
        tick_count_nxt = tick_inc;
      end else begin
        tick_count_nxt = 9'd0;
        if (!clock_phase_r) begin
          clock_phase_nxt = 1'b1;
        end else begin
          receive_shift_nxt = rx;
          clock_phase_nxt   = 1'b0;
          bits_left_nxt     = bits_left_r - 6'd1;
          if (bits_left_r == 6'd1) begin
            done   = 1'b1;
            op_nxt = OP_IDLE;
            resp   = {24'h000000, rx[7:0]};
            case (op_r)
              OP_MULTI: begin
                resp = rx_order;
              end
              OP_WRITE: begin
                command_bytes_nxt = flipped;
                poll_elapsed_nxt  = 17'd0;
                if (write_timeout_r != 16'd0) begin
                  done              = 1'b0;
                  resp              = '0;
                  bits_left_nxt     = RW_BITS;
                  receive_shift_nxt = '0;
                  op_nxt            = OP_POLL;
                end
              end
              OP_POLL: begin
                if (!poll_match) begin
                  poll_elapsed_nxt = poll_sum;
                  if (poll_sum < {1'b0, write_timeout_r}) begin
                    done              = 1'b0;
                    resp              = '0;
                    bits_left_nxt     = RW_BITS;
                    receive_shift_nxt = '0;
                    op_nxt            = OP_POLL;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    end else if (op_r == OP_IDLE) begin
      case (in_cmd)
        CMD_POWER_UP: begin
          acc             = 1'b1;
          half_period_nxt = in_value_word[7:0];
          powered_nxt     = 1'b1;
          if (in_index_word[7:0] != 8'd0) begin
            reset_level_nxt = 1'b1;
          end
        end
        CMD_POWER_DOWN: begin
          acc               = 1'b1;
          powered_nxt       = 1'b0;
          reset_level_nxt   = 1'b0;
          command_bytes_nxt = '0;
          clock_phase_nxt   = 1'b0;
        end
        CMD_SPI_MULTI, CMD_SPI_SINGLE, CMD_READ_BYTE, CMD_WRITE_BYTE: begin
          if (powered_r) begin
            acc               = 1'b1;
            receive_shift_nxt = '0;
            clock_phase_nxt   = 1'b0;
            tick_count_nxt    = 9'd0;
            case (in_cmd)
              CMD_SPI_MULTI: begin
                command_bytes_nxt = multi_raw;
                bits_left_nxt     = MULTI_BITS;
                op_nxt            = OP_MULTI;
              end
              CMD_SPI_SINGLE: begin
                command_bytes_nxt = {24'h000000, in_value_word[7:0]};
                bits_left_nxt     = 6'd8;
                op_nxt            = OP_SINGLE;
              end
              CMD_READ_BYTE: begin
                command_bytes_nxt = {rw_hi, 8'h00};
                bits_left_nxt     = RW_BITS;
                next_address_nxt  = next_address_r + 16'd1;
                op_nxt            = OP_READ;
              end
              default: begin
                command_bytes_nxt = {rw_hi, in_data_byte};
                bits_left_nxt     = RW_BITS;
                next_address_nxt  = next_address_r + 16'd1;
                write_value_nxt   = in_data_byte;
                op_nxt            = OP_WRITE;
              end
            endcase
          end
        end
        CMD_SET_POLL: begin
          if (powered_r) begin
            acc             = 1'b1;
            poll_first_nxt  = in_value_word[7:0];
            poll_second_nxt = in_value_word[15:8];
          end
        end
        CMD_FLASH_RD, CMD_EEP_RD, CMD_FLASH_WR, CMD_EEP_WR: begin
          if (powered_r) begin
            acc              = 1'b1;
            next_address_nxt = in_index_word;
            case (in_cmd)
              CMD_FLASH_RD: base_command_nxt = BASE_FLASH_RD;
              CMD_EEP_RD:   base_command_nxt = BASE_EEP_RD;
              CMD_FLASH_WR: begin
                base_command_nxt  = BASE_FLASH_WR;
                write_timeout_nxt = in_value_word;
              end
              default: begin
                base_command_nxt  = BASE_EEP_WR;
                write_timeout_nxt = in_value_word;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    bl_m1 = bits_left_nxt - 6'd1;
    if (op_nxt != OP_IDLE && bits_left_nxt != 6'd0) begin
      mosi = command_bytes_nxt[bl_m1[4:0]];
    end else begin
      mosi = command_bytes_nxt[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      powered_r       <= 1'b0;
      reset_level_r   <= 1'b0;
      half_period_r   <= '0;
      poll_first_r    <= '0;
      poll_second_r   <= '0;
      next_address_r  <= '0;
      base_command_r  <= '0;
      write_timeout_r <= '0;
      command_bytes_r <= '0;
      receive_shift_r <= '0;
      bits_left_r     <= '0;
      clock_phase_r   <= 1'b0;
      tick_count_r    <= '0;
      op_r            <= OP_IDLE;
      poll_elapsed_r  <= '0;
      write_value_r   <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (take) begin
        powered_r       <= powered_nxt;
        reset_level_r   <= reset_level_nxt;
        half_period_r   <= half_period_nxt;
        poll_first_r    <= poll_first_nxt;
        poll_second_r   <= poll_second_nxt;
        next_address_r  <= next_address_nxt;
        base_command_r  <= base_command_nxt;
        write_timeout_r <= write_timeout_nxt;
        command_bytes_r <= command_bytes_nxt;
        receive_shift_r <= receive_shift_nxt;
        bits_left_r     <= bits_left_nxt;
        clock_phase_r   <= clock_phase_nxt;
        tick_count_r    <= tick_count_nxt;
        op_r            <= op_nxt;
        poll_elapsed_r  <= poll_elapsed_nxt;
        write_value_r   <= write_value_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sck_r       <= 1'b0;
      mosi_r      <= 1'b0;
      reset_pin_r <= 1'b0;
      led_r       <= 1'b0;
      drive_r     <= 1'b0;
      busy_r      <= 1'b0;
      acc_r       <= 1'b0;
      done_r      <= 1'b0;
      resp_r      <= '0;
    end else if (take) begin
      sck_r       <= clock_phase_nxt;
      mosi_r      <= mosi;
      reset_pin_r <= reset_level_nxt;
      led_r       <= powered_nxt;
      drive_r     <= powered_nxt;
      busy_r      <= (op_nxt != OP_IDLE);
      acc_r       <= acc;
      done_r      <= done;
      resp_r      <= resp;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sck_pin      = sck_r;
  assign out_mosi_pin     = mosi_r;
  assign out_reset_pin    = reset_pin_r;
  assign out_led_pin      = led_r;
  assign out_drive_enable = drive_r;
  assign out_busy_res     = busy_r;
  assign out_accepted     = acc_r;
  assign out_done_res     = done_r;
  assign out_response     = resp_r;

endmodule

`default_nettype wire

@@ rtl/avrisp_checker.sv @@
`default_nettype none

module avrisp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [3:0]  in_cmd,
  input wire logic        out_valid,
  input wire logic        out_sck_pin,
  input wire logic        out_led_pin,
  input wire logic        out_busy_res,
  input wire logic        out_accepted,
  input wire logic        out_done_res,
  input wire logic [31:0] out_response
);
  import avrisp_pkg::*;

  a_take_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted input beat did not produce a result beat");

  a_tick_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_TICK |=> !out_accepted)
    else $error("tick beat reported as accepted request");

  a_done_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && !out_accepted)
    else $error("done beat still busy or marked accepted");

  a_resp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_response == 32'd0)
    else $error("response nonzero without done");

  a_unpowered_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_led_pin |-> !out_sck_pin && !out_busy_res)
    else $error("serial activity while unpowered");

endmodule

bind avr_isp_programming_engine avrisp_checker u_avrisp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_cmd       (in_cmd),
  .out_valid    (out_valid),
  .out_sck_pin  (out_sck_pin),
  .out_led_pin  (out_led_pin),
  .out_busy_res (out_busy_res),
  .out_accepted (out_accepted),
  .out_done_res (out_done_res),
  .out_response (out_response)
);

`default_nettype wire

@@ verif/isp_engine_checker.sv @@
`timescale 1ns / 1ps

module isp_engine_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [3:0]  in_cmd,
  input  wire logic        in_miso,
  input  wire logic [15:0] in_value_word,
  input  wire logic [15:0] in_index_word,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_sck_pin,
  input  wire logic        out_mosi_pin,
  input  wire logic        out_reset_pin,
  input  wire logic        out_led_pin,
  input  wire logic        out_drive_enable,
  input  wire logic        out_busy_res,
  input  wire logic        out_accepted,
  input  wire logic        out_done_res,
  input  wire logic [31:0] out_response,
  output int               mismatches,
  output int               waiting,
  output int               checked,
  output int               finished_xfers
);
  import avrisp_pkg::*;

  typedef enum logic [2:0] {
    XF_IDLE, XF_RAW4, XF_RAW1, XF_READ, XF_WRITE, XF_POLL
  } xfer_t;

  typedef struct packed {
    logic        sck;
    logic        mosi;
    logic        rst;
    logic        led;
    logic        drive;
    logic        busy;
    logic        acc;
    logic        done;
    logic [31:0] resp;
  } pins_t;

  logic        powered;
  logic        rst_lvl;
  logic [7:0]  half_per;
  logic [7:0]  poll_a;
  logic [7:0]  poll_b;
  logic [15:0] next_addr;
  logic [7:0]  base_cmd;
  logic [15:0] wr_timeout;
  logic [31:0] cmd_stream;
  logic [31:0] rx_shift;
  logic [5:0]  bits_left;
  logic        sck_phase;
  logic [8:0]  tick_cnt;
  xfer_t       xfer;
  logic [16:0] poll_elapsed;
  logic [7:0]  wr_val;

  pins_t expected_pins[$];

  function automatic logic [8:0] half_ticks();
    return (half_per == 8'd0) ? 9'd256 : {1'b0, half_per};
  endfunction

  task automatic clear_state();
    powered = 1'b0;
    rst_lvl = 1'b0;
    half_per = '0;
    poll_a = '0;
    poll_b = '0;
    next_addr = '0;
    base_cmd = '0;
    wr_timeout = '0;
    cmd_stream = '0;
    rx_shift = '0;
    bits_left = '0;
    sck_phase = 1'b0;
    tick_cnt = '0;
    xfer = XF_IDLE;
    poll_elapsed = '0;
    wr_val = '0;
  endtask

  task automatic start_xfer(input logic [31:0] stream, input logic [5:0] nbits,
                            input xfer_t kind);
    cmd_stream = stream;
    bits_left = nbits;
    rx_shift = '0;
    sck_phase = 1'b0;
    tick_cnt = '0;
    xfer = kind;
  endtask

  function automatic logic [31:0] rw_frame(input logic [7:0] last);
    logic [15:0] a;
    logic [7:0]  first;
    a = next_addr;
    next_addr = next_addr + 16'd1;
    if (base_cmd[7]) a = {a[14:0], 1'b0};
    first = a[0] ? (base_cmd | FLASH_HIGH_BIT) : base_cmd;
    return {first, 1'b0, a[15:9], a[8:1], last};
  endfunction

  task automatic advance_tick(input logic miso, output logic done, output logic [31:0] resp);
    logic [7:0] last;
    done = 1'b0;
    resp = '0;
    if (xfer == XF_IDLE || bits_left == 6'd0) begin
      xfer = XF_IDLE;
      return;
    end
    tick_cnt = tick_cnt + 9'd1;
    if (tick_cnt < half_ticks()) return;
    tick_cnt = '0;
    if (!sck_phase) begin
      sck_phase = 1'b1;
      return;
    end
    rx_shift = {rx_shift[30:0], miso};
    sck_phase = 1'b0;
    bits_left = bits_left - 6'd1;
    if (bits_left != 6'd0) return;
    last = rx_shift[7:0];
    resp = {24'd0, last};
    case (xfer)
      XF_RAW4: resp = {rx_shift[7:0], rx_shift[15:8], rx_shift[23:16], rx_shift[31:24]};
      XF_WRITE: begin
        cmd_stream = cmd_stream ^ POLL_FLIP;
        poll_elapsed = '0;
        if (wr_timeout != 16'd0) begin
          start_xfer(cmd_stream, RW_BITS, XF_POLL);
          return;
        end
      end
      XF_POLL: begin
        if (!(last == wr_val && last != poll_a && last != poll_b)) begin
          poll_elapsed = poll_elapsed + 17'(32 * half_ticks());
          if (poll_elapsed < {1'b0, wr_timeout}) begin
            start_xfer(cmd_stream, RW_BITS, XF_POLL);
            return;
          end
        end
      end
      default: ;
    endcase
    xfer = XF_IDLE;
    done = 1'b1;
  endtask

  task automatic predict_pins(input logic [3:0] c, input logic m, input logic [15:0] v,
                              input logic [15:0] x, input logic [7:0] d, output pins_t p);
    logic        busy;
    logic        acc;
    logic        done;
    logic [31:0] resp;
    busy = (xfer != XF_IDLE);
    acc = 1'b0;
    done = 1'b0;
    resp = '0;
    if (c == CMD_TICK) begin
      advance_tick(m, done, resp);
    end else if (!busy && c <= CMD_WRITE_BYTE) begin
      if (c == CMD_POWER_UP) begin
        half_per = v[7:0];
        if (x[7:0] != 8'd0) rst_lvl = 1'b1;
        powered = 1'b1;
        acc = 1'b1;
      end else if (c == CMD_POWER_DOWN) begin
        powered = 1'b0;
        rst_lvl = 1'b0;
        cmd_stream = '0;
        sck_phase = 1'b0;
        acc = 1'b1;
      end else if (powered) begin
        acc = 1'b1;
        case (c)
          CMD_SPI_MULTI:  start_xfer({v[7:0], v[15:8], x[7:0], x[15:8]}, 6'd32, XF_RAW4);
          CMD_SPI_SINGLE: start_xfer({24'd0, v[7:0]}, 6'd8, XF_RAW1);
          CMD_SET_POLL: begin
            poll_a = v[7:0];
            poll_b = v[15:8];
          end
          CMD_FLASH_RD: begin
            next_addr = x;
            base_cmd = BASE_FLASH_RD;
          end
          CMD_EEP_RD: begin
            next_addr = x;
            base_cmd = BASE_EEP_RD;
          end
          CMD_FLASH_WR: begin
            next_addr = x;
            wr_timeout = v;
            base_cmd = BASE_FLASH_WR;
          end
          CMD_EEP_WR: begin
            next_addr = x;
            wr_timeout = v;
            base_cmd = BASE_EEP_WR;
          end
          CMD_READ_BYTE: start_xfer(rw_frame(8'd0), RW_BITS, XF_READ);
          default: begin
            wr_val = d;
            start_xfer(rw_frame(d), RW_BITS, XF_WRITE);
          end
        endcase
      end
    end
    p.sck = sck_phase;
    p.mosi = (xfer != XF_IDLE && bits_left != 6'd0) ? cmd_stream[bits_left - 6'd1]
                                                    : cmd_stream[0];
    p.rst = rst_lvl;
    p.led = powered;
    p.drive = powered;
    p.busy = (xfer != XF_IDLE);
    p.acc = acc;
    p.done = done;
    p.resp = done ? resp : '0;
    if (done) finished_xfers++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    $display("mismatch %s at result %0d: expected %h, got %h", what, checked, want_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    pins_t got;
    pins_t want;
    pins_t p;
    if (!rst_n) begin
      clear_state();
      expected_pins.delete();
      mismatches = 0;
      checked = 0;
      finished_xfers = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_sck_pin, out_mosi_pin, out_reset_pin, out_led_pin, out_drive_enable,
               out_busy_res, out_accepted, out_done_res, out_response};
        if (expected_pins.size() == 0) begin
          report_mismatch("unexpected beat", '0, got.resp);
        end else begin
          want = expected_pins.pop_front();
          if (got.sck !== want.sck) report_mismatch("sck_pin", want.sck, got.sck);
          if (got.mosi !== want.mosi) report_mismatch("mosi_pin", want.mosi, got.mosi);
          if (got.rst !== want.rst) report_mismatch("reset_pin", want.rst, got.rst);
          if (got.led !== want.led) report_mismatch("led_pin", want.led, got.led);
          if (got.drive !== want.drive) report_mismatch("drive_enable", want.drive, got.drive);
          if (got.busy !== want.busy) report_mismatch("busy_res", want.busy, got.busy);
          if (got.acc !== want.acc) report_mismatch("accepted", want.acc, got.acc);
          if (got.done !== want.done) report_mismatch("done_res", want.done, got.done);
          if (got.resp !== want.resp) report_mismatch("response", want.resp, got.resp);
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        predict_pins(in_cmd, in_miso, in_value_word, in_index_word, in_data_byte, p);
        expected_pins.push_back(p);
      end
    end
    waiting = expected_pins.size();
  end

endmodule

@@ verif/tb_avr_isp_programming_engine.sv @@
`timescale 1ns / 1ps

module tb_avr_isp_programming_engine;
  import avrisp_pkg::*;

  localparam logic [3:0] CMD_UNUSED_LO = 4'd12;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int RANDOM_REQUESTS = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_cmd;
  logic        in_miso;
  logic [15:0] in_value_word;
  logic [15:0] in_index_word;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_sck_pin;
  logic        out_mosi_pin;
  logic        out_reset_pin;
  logic        out_led_pin;
  logic        out_drive_enable;
  logic        out_busy_res;
  logic        out_accepted;
  logic        out_done_res;
  logic [31:0] out_response;

  int mismatches;
  int waiting;
  int checked;
  int finished_xfers;

  int          burst_left;
  bit          steady;
  int          cur_p;
  logic [15:0] cur_tmo;
  logic [7:0]  poll_a;
  logic [7:0]  poll_b;
  int          n_req;
  int          n_tick;
  int          cycles;

  avr_isp_programming_engine DUT (.*);

  isp_engine_checker engine_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, waiting);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : rx_stall
    int mode;
    int mode_left;
    int hold_left;
    int cyc;
    out_ready = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 3000 || cyc == 60000) hold_left = 250;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  task automatic send_beat(input logic [3:0] c, input logic m, input logic [15:0] v,
                           input logic [15:0] x, input logic [7:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      steady = ($urandom_range(0, 4) == 0);
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_miso <= m;
    in_value_word <= v;
    in_index_word <= x;
    in_data_byte <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (c == CMD_TICK) n_tick++;
    else if (c <= CMD_WRITE_BYTE) n_req++;
  endtask

  task automatic send_req(input logic [3:0] c, input logic [15:0] v, input logic [15:0] x);
    send_beat(c, 1'($urandom_range(0, 1)), v, x, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_xfer(input int nbits, input logic [7:0] reply);
    int total;
    int bit_i;
    logic m;
    total = nbits * 2 * cur_p;
    for (int k = 0; k < total; k++) begin
      bit_i = k / (2 * cur_p);
      if (bit_i >= nbits - 8) m = reply[nbits - 1 - bit_i];
      else m = 1'($urandom_range(0, 1));
      send_beat(CMD_TICK, m, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                8'($urandom_range(0, 255)));
    end
  endtask

  task automatic power_up(input logic [7:0] hp, input logic [15:0] lvl);
    send_req(CMD_POWER_UP, {8'($urandom_range(0, 255)), hp}, lvl);
    cur_p = (hp == 8'd0) ? 256 : int'(hp);
  endtask

  task automatic set_poll(input logic [15:0] v);
    send_req(CMD_SET_POLL, v, 16'($urandom_range(0, 65535)));
    poll_a = v[7:0];
    poll_b = v[15:8];
  endtask

  task automatic raw1(input logic [15:0] v);
    send_req(CMD_SPI_SINGLE, v, 16'($urandom_range(0, 65535)));
    run_xfer(8, 8'($urandom_range(0, 255)));
  endtask

  task automatic raw4(input logic [15:0] v, input logic [15:0] x, input logic [7:0] reply);
    send_req(CMD_SPI_MULTI, v, x);
    run_xfer(32, reply);
  endtask

  task automatic read_bytes(input int n);
    for (int i = 0; i < n; i++) begin
      send_req(CMD_READ_BYTE, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      run_xfer(32, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic write_bytes(input int n, input logic [7:0] d0, input bit miss);
    int polls;
    logic [7:0] d;
    logic [7:0] reply;
    bit good;
    for (int i = 0; i < n; i++) begin
      d = (i == 0) ? d0 : 8'($urandom_range(0, 255));
      send_beat(CMD_WRITE_BYTE, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), d);
      run_xfer(32, 8'($urandom_range(0, 255)));
      if (cur_tmo != 16'd0) begin
        polls = (int'(cur_tmo) + 32 * cur_p - 1) / (32 * cur_p);
        for (int k = 1; k <= polls; k++) begin
          good = !miss && (k >= 3 || $urandom_range(0, 2) == 0);
          reply = good ? d : 8'($urandom_range(0, 255));
          run_xfer(32, reply);
          if (reply == d && d != poll_a && d != poll_b) break;
        end
      end
    end
  endtask

  task automatic read_seq(input bit eep, input logic [15:0] addr, input int n);
    send_req(eep ? CMD_EEP_RD : CMD_FLASH_RD, 16'($urandom_range(0, 65535)), addr);
    read_bytes(n);
  endtask

  task automatic write_seq(input bit eep, input logic [15:0] addr, input logic [15:0] tmo,
                           input int n, input logic [7:0] d0, input bit miss);
    send_req(eep ? CMD_EEP_WR : CMD_FLASH_WR, tmo, addr);
    cur_tmo = tmo;
    write_bytes(n, d0, miss);
  endtask

  task automatic noise_item();
    logic [3:0]  c;
    logic [15:0] v;
    c = 4'($urandom_range(0, 15));
    v = 16'($urandom_range(0, 65535));
    if (c == CMD_POWER_UP) v[7:0] = 8'($urandom_range(1, 4));
    if (c == CMD_FLASH_WR || c == CMD_EEP_WR) v = 16'($urandom_range(0, 200));
    send_req(c, v, 16'($urandom_range(0, 65535)));
    if (c == CMD_POWER_UP) cur_p = int'(v[7:0]);
    if (c == CMD_POWER_DOWN) power_up(8'($urandom_range(1, 4)), 16'($urandom_range(0, 65535)));
    run_xfer(32, 8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int pick;
    int start_req;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_TICK;
    in_miso = 1'b0;
    in_value_word = '0;
    in_index_word = '0;
    in_data_byte = '0;
    burst_left = 0;
    steady = 1'b0;
    cur_p = 256;
    cur_tmo = '0;
    poll_a = '0;
    poll_b = '0;
    n_req = 0;
    n_tick = 0;
    cycles = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_beat(CMD_TICK, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_req(CMD_SPI_MULTI, 16'h1234, 16'h5678);
    send_req(CMD_UNUSED_LO, 16'hFFFF, 16'hFFFF);
    send_req(CMD_UNUSED_HI, 16'h0000, 16'h0000);
    power_up(8'd1, 16'h00FF);
    read_bytes(1);
    cur_tmo = '0;
    write_bytes(1, 8'hC3, 1'b0);
    power_up(8'd0, 16'hFF00);
    raw1(16'hFFA5);
    power_up(8'd255, 16'h0000);
    raw4(16'hFFFF, 16'hFFFF, 8'hFF);
    power_up(8'd1, 16'h0000);
    raw4(16'h0000, 16'h0000, 8'h00);
    set_poll(16'h00FF);
    read_seq(1'b0, 16'hFFFF, 2);
    read_seq(1'b1, 16'h8001, 1);
    write_seq(1'b0, 16'h1234, 16'h0000, 1, 8'h00, 1'b0);
    write_seq(1'b1, 16'h00FF, 16'hFFFF, 1, 8'h5A, 1'b0);
    write_seq(1'b0, 16'h7FFE, 16'd40, 1, 8'hFF, 1'b0);
    write_seq(1'b0, 16'h0001, 16'd100, 1, 8'h3C, 1'b1);
    send_req(CMD_SPI_SINGLE, 16'h0081, 16'h0000);
    send_req(CMD_POWER_DOWN, 16'h0000, 16'h0000);
    send_req(CMD_POWER_UP, 16'h0003, 16'h0001);
    run_xfer(8, 8'h5A);
    send_req(CMD_POWER_DOWN, 16'h0000, 16'h0000);
    send_req(CMD_SPI_MULTI, 16'hA5A5, 16'h5A5A);
    power_up(8'd2, 16'h0001);

    start_req = n_req;
    while (n_req - start_req < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        power_up(8'($urandom_range(1, 4)), 16'($urandom_range(0, 65535)));
      end else if (pick < 11) begin
        power_up(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        raw1(16'($urandom_range(0, 65535)));
        power_up(8'($urandom_range(1, 4)), 16'($urandom_range(0, 65535)));
      end else if (pick < 26) begin
        raw4(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
             8'($urandom_range(0, 255)));
      end else if (pick < 36) begin
        raw1(16'($urandom_range(0, 65535)));
      end else if (pick < 41) begin
        set_poll(16'($urandom_range(0, 65535)));
      end else if (pick < 61) begin
        read_seq(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                 $urandom_range(1, 4));
      end else if (pick < 86) begin
        write_seq(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                  ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 32 * cur_p * 5)),
                  $urandom_range(1, 3), 8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 93) begin
        send_req(CMD_POWER_DOWN, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          send_req(4'($urandom_range(int'(CMD_SPI_MULTI), int'(CMD_WRITE_BYTE))),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        power_up(8'($urandom_range(1, 4)), 16'($urandom_range(0, 65535)));
      end else if (pick < 96) begin
        send_req(CMD_SPI_SINGLE, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        noise_item();
      end else begin
        noise_item();
      end
    end
    in_valid <= 1'b0;

    while (waiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("covered %0d requests and %0d ticks in %0d cycles", n_req, n_tick, cycles);
    $display("checked %0d result beats, %0d serial sequences completed", checked,
             finished_xfers);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
